@@ rtl/f64c_pkg.sv @@
// Shared types, constants and the modular add for the Fletcher-64 checksum core.
package f64c_pkg;

    localparam int unsigned WORD_BITS   = 32;
    localparam int unsigned BYTE_BITS   = 8;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [WORD_BITS-1:0] SUM_MOD = {WORD_BITS{1'b1}};

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic                 last;
    } t_word;

    // Adds a residue and any 32-bit value modulo all ones, with an end-around carry.
    // The second operand may itself be all ones.
    function automatic logic [WORD_BITS-1:0] add_mod(
        input logic [WORD_BITS-1:0] a,
        input logic [WORD_BITS-1:0] b
    );
        logic [WORD_BITS:0]   s;
        logic [WORD_BITS-1:0] r;
        s = {1'b0, a} + {1'b0, b};
        r = s[WORD_BITS-1:0] + {{(WORD_BITS-1){1'b0}}, s[WORD_BITS]};
        // An all-ones residue stands for zero.
        if (r == SUM_MOD) begin
            r = '0;
        end
        return r;
    endfunction

endpackage

@@ rtl/f64c_front.sv @@
// Front part: packs message bytes little-endian into words and marks the final word.
module f64c_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [f64c_pkg::BYTE_BITS-1:0]      i_data_byte,
    input  logic                                i_last_byte,
    input  logic                                i_q_full,
    output logic                                o_q_push,
    output f64c_pkg::t_word                     o_q_word
);

    logic [23:0]                        r_partial;
    logic [23:0]                        n_partial;
    logic [1:0]                         r_pos;
    logic [1:0]                         n_pos;
    logic [f64c_pkg::WORD_BITS-1:0]     word;
    logic                               accept;
    logic                               word_done;

    assign full   = i_q_full;
    assign accept = push && !full;

    always_comb begin
        word = {8'h00, r_partial};
        unique case (r_pos)
            2'd0: word[7:0]   = i_data_byte;
            2'd1: word[15:8]  = i_data_byte;
            2'd2: word[23:16] = i_data_byte;
            2'd3: word[31:24] = i_data_byte;
            default: word = {8'h00, r_partial};
        endcase
    end

    assign word_done = (r_pos == 2'd3) || i_last_byte;

    always_comb begin
        n_partial = r_partial;
        n_pos     = r_pos;
        if (accept) begin
            if (word_done) begin
                n_partial = '0;
                n_pos     = '0;
            end else begin
                n_partial = word[23:0];
                n_pos     = r_pos + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_pos     <= '0;
        end else begin
            r_partial <= n_partial;
            r_pos     <= n_pos;
        end
    end

    assign o_q_push      = accept && word_done;
    assign o_q_word.word = word;
    assign o_q_word.last = i_last_byte;

    // At the start of a group the partial word holds no bytes.
    a_partial_clear_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos == 2'd0) |-> (r_partial == 24'h0))
        else $error("partial word not cleared at start of group");

    a_pos_wraps_on_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push |=> (r_pos == 2'd0))
        else $error("byte position not reset after a word was emitted");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push |-> !i_q_full)
        else $error("word pushed into a full queue");

endmodule

@@ rtl/f64c_queue.sv @@
// Short word queue between the byte packer and the sum accumulator.
module f64c_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  f64c_pkg::t_word     i_wr,
    output logic                o_full,
    output logic                o_empty,
    input  logic                i_pop,
    output f64c_pkg::t_word     o_rd
);

    localparam logic [f64c_pkg::QPTR_BITS-1:0] LAST_PTR =
        f64c_pkg::QPTR_BITS'(f64c_pkg::QUEUE_DEPTH - 1);
    localparam logic [f64c_pkg::QCNT_BITS-1:0] FULL_CNT =
        f64c_pkg::QCNT_BITS'(f64c_pkg::QUEUE_DEPTH);

    f64c_pkg::t_word                    r_mem [f64c_pkg::QUEUE_DEPTH];
    logic [f64c_pkg::QPTR_BITS-1:0]     r_wr_ptr;
    logic [f64c_pkg::QPTR_BITS-1:0]     r_rd_ptr;
    logic [f64c_pkg::QCNT_BITS-1:0]     r_count;
    logic                               do_push;
    logic                               do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rd    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count beyond depth");

    a_ptrs_meet_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers differ while empty");

    a_push_only_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> !o_empty)
        else $error("queue empty after a push");

endmodule

@@ rtl/f64c_back.sv @@
// Back part: folds words into the two running sums and holds the finished checksum.
module f64c_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_empty,
    input  f64c_pkg::t_word                     i_q_word,
    output logic                                o_q_pop,
    output logic                                empty,
    input  logic                                pop,
    output logic [f64c_pkg::WORD_BITS-1:0]      o_sum_low,
    output logic [f64c_pkg::WORD_BITS-1:0]      o_sum_high
);

    logic [f64c_pkg::WORD_BITS-1:0]     r_first;
    logic [f64c_pkg::WORD_BITS-1:0]     r_second;
    logic [f64c_pkg::WORD_BITS-1:0]     n_first;
    logic [f64c_pkg::WORD_BITS-1:0]     n_second;
    logic                               r_out_valid;
    logic [f64c_pkg::WORD_BITS-1:0]     r_sum_low;
    logic [f64c_pkg::WORD_BITS-1:0]     r_sum_high;
    logic                               out_slot_free;
    logic                               take;

    // A final word may only be folded when the result register can take it.
    assign out_slot_free = !r_out_valid || pop;
    assign take          = !i_q_empty && (!i_q_word.last || out_slot_free);
    assign o_q_pop       = take;

    assign n_first  = f64c_pkg::add_mod(r_first, i_q_word.word);
    assign n_second = f64c_pkg::add_mod(r_second, n_first);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first     <= '0;
            r_second    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                if (i_q_word.last) begin
                    r_first  <= '0;
                    r_second <= '0;
                end else begin
                    r_first  <= n_first;
                    r_second <= n_second;
                end
            end
            if (take && i_q_word.last) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_q_word.last) begin
            r_sum_low  <= n_first;
            r_sum_high <= n_second;
        end
    end

    assign empty      = !r_out_valid;
    assign o_sum_low  = r_sum_low;
    assign o_sum_high = r_sum_high;

    a_first_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_first != f64c_pkg::SUM_MOD)
        else $error("first sum holds the all-ones residue");

    a_second_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second != f64c_pkg::SUM_MOD)
        else $error("second sum holds the all-ones residue");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !pop) |=> (r_out_valid && $stable(r_sum_low)
                                   && $stable(r_sum_high)))
        else $error("checksum changed before it was taken");

    a_sums_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_q_word.last) |=> (r_first == '0 && r_second == '0))
        else $error("running sums not cleared after the final word");

endmodule

@@ rtl/fletcher64_checksum_core.sv @@
// Top level of the Fletcher-64 checksum core: byte packer, word queue, sum accumulator.
//
//   channel  | handshake         | word contents
//   ---------+-------------------+------------------------------------------
//   input    | push / full       | i_data_byte (8 bits), i_last_byte
//   result   | empty / pop       | o_sum_low (32 bits), o_sum_high (32 bits)
//
// One byte is accepted per cycle while full is low; a checksum reaches the result
// ports via the queue write and the result register, waiting while another is unread.
// The accumulator folds one queued word per cycle with two end-around-carry adds.
// Reset is synchronous and clears the packer, the queue and both sums.
// full rises when a checksum waits unread, the next final word is stuck in the
// queue and one more word arrives behind it.
module fletcher64_checksum_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [f64c_pkg::BYTE_BITS-1:0]      i_data_byte,
    input  logic                                i_last_byte,
    output logic                                empty,
    input  logic                                pop,
    output logic [f64c_pkg::WORD_BITS-1:0]      o_sum_low,
    output logic [f64c_pkg::WORD_BITS-1:0]      o_sum_high
);

    logic               q_full;
    logic               q_empty;
    logic               q_push;
    logic               q_pop;
    f64c_pkg::t_word    q_wr;
    f64c_pkg::t_word    q_rd;

    f64c_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_word    (q_wr)
    );

    f64c_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wr    (q_wr),
        .o_full  (q_full),
        .o_empty (q_empty),
        .i_pop   (q_pop),
        .o_rd    (q_rd)
    );

    f64c_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_q_word   (q_rd),
        .o_q_pop    (q_pop),
        .empty      (empty),
        .pop        (pop),
        .o_sum_low  (o_sum_low),
        .o_sum_high (o_sum_high)
    );

endmodule

@@ bench/fletcher64_checksum_core_tb.sv @@
// Self-checking testbench for the Fletcher-64 checksum core.
`timescale 1ns / 1ps

module fletcher64_checksum_core_tb;

    localparam int unsigned CLK_HALF    = 6;
    localparam int unsigned RESET_LEN   = 5;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned TAIL_CYCLES = 8;
    localparam logic [63:0] RESIDUE_MOD = 64'h0000_0000_FFFF_FFFF;

    typedef struct {
        logic [f64c_pkg::WORD_BITS-1:0] sum_low;
        logic [f64c_pkg::WORD_BITS-1:0] sum_high;
    } t_checksum;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           push        = 1'b0;
    logic                           full;
    logic [f64c_pkg::BYTE_BITS-1:0] i_data_byte = '0;
    logic                           i_last_byte = 1'b0;
    logic                           empty;
    logic                           pop         = 1'b0;
    logic [f64c_pkg::WORD_BITS-1:0] o_sum_low;
    logic [f64c_pkg::WORD_BITS-1:0] o_sum_high;

    fletcher64_checksum_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .empty       (empty),
        .pop         (pop),
        .o_sum_low   (o_sum_low),
        .o_sum_high  (o_sum_high)
    );

    // Predicted checksum state.
    logic [23:0]                    pack_bytes;
    logic [1:0]                     pack_count;
    logic [f64c_pkg::WORD_BITS-1:0] run_sum_a;
    logic [f64c_pkg::WORD_BITS-1:0] run_sum_b;
    t_checksum                      expected_checksums[$];

    int unsigned error_count   = 0;
    int unsigned cycle_count   = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // The main process flips hold_toggle; the receiver counts out the hold itself.
    logic        hold_toggle = 1'b0;
    logic        hold_seen   = 1'b0;
    int unsigned hold_left   = 0;

    initial begin
        forever begin
            #(CLK_HALF) i_clk = ~i_clk;
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("fletcher64_checksum_core regression: fail");
                $finish;
            end
        end
    end

    function automatic logic [f64c_pkg::WORD_BITS-1:0] residue_add(
        input logic [f64c_pkg::WORD_BITS-1:0] a,
        input logic [f64c_pkg::WORD_BITS-1:0] b
    );
        logic [63:0] t;
        t = ({32'b0, a} + {32'b0, b}) % RESIDUE_MOD;
        return t[f64c_pkg::WORD_BITS-1:0];
    endfunction

    function automatic void clear_sums();
        pack_bytes = '0;
        pack_count = '0;
        run_sum_a  = '0;
        run_sum_b  = '0;
    endfunction

    // Applies one accepted byte; a final byte queues the expected checksum.
    function automatic void absorb_byte(input logic [f64c_pkg::BYTE_BITS-1:0] b,
                                        input logic l);
        logic [f64c_pkg::WORD_BITS-1:0] word;
        t_checksum                      cs;
        word = {8'h00, pack_bytes} | ({24'h0, b} << (8 * pack_count));
        if (pack_count == 2'd3 || l) begin
            run_sum_a  = residue_add(run_sum_a, word);
            run_sum_b  = residue_add(run_sum_b, run_sum_a);
            pack_bytes = '0;
            pack_count = '0;
        end else begin
            pack_bytes = word[23:0];
            pack_count = pack_count + 2'd1;
        end
        if (l) begin
            cs.sum_low  = run_sum_a;
            cs.sum_high = run_sum_b;
            expected_checksums.push_back(cs);
            clear_sums();
        end
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [f64c_pkg::WORD_BITS-1:0] got,
                                   input logic [f64c_pkg::WORD_BITS-1:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
        error_count++;
    endtask

    // Result side: check each popped word, then decide whether to pop next cycle.
    always @(posedge i_clk) begin
        t_checksum cs;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (expected_checksums.size() == 0) begin
                    report_mismatch("unexpected checksum, sum_low", o_sum_low, '0);
                end else begin
                    cs = expected_checksums.pop_front();
                    if (o_sum_low !== cs.sum_low) begin
                        report_mismatch("sum_low", o_sum_low, cs.sum_low);
                    end
                    if (o_sum_high !== cs.sum_high) begin
                        report_mismatch("sum_high", o_sum_high, cs.sum_high);
                    end
                end
            end
            if (hold_toggle != hold_seen) begin
                hold_seen <= hold_toggle;
                hold_left <= HOLD_CYCLES;
                pop       <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                pop       <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end else begin
            pop <= 1'b0;
        end
    end

    // Offers one byte, idling first at the current rate, and waits until it is taken.
    task automatic send_byte(input logic [f64c_pkg::BYTE_BITS-1:0] b, input logic l);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push        <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= l;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        absorb_byte(b, l);
    endtask

    task automatic send_message(input logic [f64c_pkg::BYTE_BITS-1:0] bytes[$]);
        for (int i = 0; i < bytes.size(); i++) begin
            send_byte(bytes[i], i == bytes.size() - 1);
        end
    endtask

    task automatic stop_sending();
        push <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (expected_checksums.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [f64c_pkg::BYTE_BITS-1:0] random_byte();
        int unsigned k;
        k = $urandom_range(15);
        if (k == 0) return 8'h00;
        if (k == 1) return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    function automatic int unsigned random_length();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 80) return $urandom_range(1, 9);
        if (r < 95) return $urandom_range(10, 24);
        return $urandom_range(25, 64);
    endfunction

    task automatic send_random_messages(input int unsigned byte_budget);
        logic [f64c_pkg::BYTE_BITS-1:0] msg[$];
        int unsigned                    sent;
        int unsigned                    len;
        sent = 0;
        while (sent < byte_budget) begin
            len = random_length();
            msg = {};
            repeat (len) msg.push_back(random_byte());
            send_message(msg);
            sent += len;
        end
    endtask

    // Messages of one, two, three and five bytes put the final byte at group positions
    // zero to two, with all-zero and all-one bytes.
    task automatic test_group_positions();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_message('{8'h00});
        send_message('{8'hFF});
        send_message('{8'hFF, 8'h00});
        send_message('{8'h12, 8'h34, 8'h56});
        send_message('{8'hA5, 8'h5A, 8'hFF, 8'h01, 8'h80});
        stop_sending();
        wait_drained();
    endtask

    // A sum that reaches all ones must come out as zero, in either half.
    task automatic test_all_ones_residue();
        send_message('{8'hFF, 8'hFF, 8'hFF, 8'hFF});
        send_message('{8'h01, 8'h00, 8'h00, 8'h00, 8'hFD, 8'hFF, 8'hFF, 8'hFF});
        stop_sending();
        wait_drained();
    endtask

    task automatic test_random_traffic(input int unsigned s_pct, input int unsigned r_pct,
                                       input int unsigned byte_budget);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        send_random_messages(byte_budget);
        stop_sending();
    endtask

    // The receiver stalls for a long stretch while short messages keep coming,
    // so the word queue fills and full holds the sender off.
    task automatic test_result_backpressure();
        logic [f64c_pkg::BYTE_BITS-1:0] msg[$];
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_toggle   <= ~hold_toggle;
        repeat (40) begin
            msg = {};
            repeat ($urandom_range(1, 3)) msg.push_back(random_byte());
            send_message(msg);
        end
        stop_sending();
        wait_drained();
    endtask

    // The sender goes quiet until every checksum is out, then carries on.
    task automatic test_sender_pause();
        send_idle_pct = 12;
        recv_idle_pct = 12;
        send_random_messages(60);
        stop_sending();
        wait_drained();
        send_random_messages(60);
        stop_sending();
    endtask

    initial begin
        clear_sums();
        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_group_positions();
        test_all_ones_residue();
        test_random_traffic(12, 88, 620);
        test_random_traffic(88, 12, 620);
        test_random_traffic(0, 0, 620);
        test_result_backpressure();
        test_sender_pause();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("fletcher64_checksum_core regression: pass");
        end else begin
            $display("fletcher64_checksum_core regression: fail");
        end
        $finish;
    end

endmodule
